// ----- rtl/assert_macros.svh -----
// assertion macros included by the rtl parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/ffsi_pkg.sv -----
// shared types, constants and helper function of the sequence file indexer
package ffsi_pkg;

    localparam int OFFSET_BITS    = 32;
    localparam int COLUMN_BITS    = 16;
    localparam int LINE_BITS      = 32;
    localparam int BAL_BITS       = 16;
    localparam int TDATA_BITS     = 96;
    localparam int TUSER_BITS     = 2;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_FASTA   = 8'h3E;
    localparam logic [7:0] CHAR_FASTQ   = 8'h40;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;

    localparam logic [7:0] QUAL_MIN_RESET = 8'd33;
    localparam logic [7:0] QUAL_MAX_RESET = 8'd74;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_QUAL_MIN = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_QUAL_MAX = 1'b1;

    localparam logic signed [BAL_BITS-1:0] BAL_MAX = {1'b0, {(BAL_BITS-1){1'b1}}};
    localparam logic signed [BAL_BITS-1:0] BAL_MIN = {1'b1, {(BAL_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_START,
        MODE_FASTA,
        MODE_FQSEQ,
        MODE_FQQUAL
    } t_mode;

    typedef enum logic [2:0] {
        ROLE_LSTART,
        ROLE_HEADER,
        ROLE_DNA,
        ROLE_QUAL,
        ROLE_SKIP
    } t_role;

    typedef enum logic [1:0] {
        KIND_ID,
        KIND_RECORD,
        KIND_ERROR
    } t_kind;

    typedef enum logic [1:0] {
        ERR_SEQ,
        ERR_QUAL,
        ERR_MALFORMED
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_item;

    typedef struct packed {
        logic            valid;
        t_kind           event_kind;
        logic [7:0]      id_byte;
        logic [31:0]     record_offset;
        logic            record_is_fastq;
        t_err            error_code;
        logic [31:0]     error_line;
        logic [15:0]     error_column;
    } t_event;

    function automatic logic is_dna(input logic [7:0] b);
        return b inside {"a", "c", "g", "t", "n", "A", "C", "G", "T", "N"};
    endfunction

endpackage

// ----- rtl/ffsi_in_reg.sv -----
// input register stage for incoming file bytes
module ffsi_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ffsi_pkg::t_item i_item,
    input  logic          i_take,
    output logic          o_valid,
    output ffsi_pkg::t_item o_item
);
    import ffsi_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- rtl/ffsi_parser.sv -----
// record parser state and per-byte event logic
`include "assert_macros.svh"

module ffsi_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  ffsi_pkg::t_item  i_item,
    input  logic [7:0]       i_qual_min,
    input  logic [7:0]       i_qual_max,
    output ffsi_pkg::t_event o_event
);
    import ffsi_pkg::*;

    t_mode                       r_mode, n_mode;
    t_role                       r_role, n_role;
    logic                        r_id_open, n_id_open;
    logic [OFFSET_BITS-1:0]      r_offset, n_offset;
    logic [LINE_BITS-1:0]        r_line, n_line;
    logic [COLUMN_BITS-1:0]      r_col, n_col;
    logic signed [BAL_BITS-1:0]  r_bal, n_bal;
    logic                        r_halted, n_halted;

    logic [COLUMN_BITS-1:0] col_inc;
    logic [7:0]             b;
    t_role                  role_eff;
    logic                   hdr;
    logic                   err;
    t_err                   err_code;
    logic [15:0]            err_col;
    logic                   bal_up;
    logic                   bal_dn;

    assign b       = i_item.data_byte;
    assign col_inc = (r_col != '1) ? r_col + 1'b1 : r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_START;
            r_role    <= ROLE_LSTART;
            r_id_open <= 1'b0;
            r_offset  <= '0;
            r_line    <= LINE_BITS'(1);
            r_col     <= '0;
            r_bal     <= '0;
            r_halted  <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_role    <= n_role;
            r_id_open <= n_id_open;
            r_offset  <= n_offset;
            r_line    <= n_line;
            r_col     <= n_col;
            r_bal     <= n_bal;
            r_halted  <= n_halted;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_role    = r_role;
        n_id_open = r_id_open;
        n_offset  = r_offset;
        n_line    = r_line;
        n_col     = r_col;
        n_bal     = r_bal;
        n_halted  = r_halted;
        o_event   = '0;
        role_eff  = r_role;
        hdr       = 1'b0;
        err       = 1'b0;
        err_code  = ERR_MALFORMED;
        err_col   = 16'd1;
        bal_up    = 1'b0;
        bal_dn    = 1'b0;

        if (i_step && !r_halted) begin
            n_offset = r_offset + 1'b1;
            if (b != CHAR_NEWLINE) begin
                n_col = col_inc;
                if (r_role == ROLE_LSTART) begin
                    case (r_mode)
                        MODE_START: begin
                            if (b == CHAR_FASTA) begin
                                n_mode = MODE_FASTA;
                                hdr    = 1'b1;
                            end else if (b == CHAR_FASTQ) begin
                                n_mode = MODE_FQSEQ;
                                hdr    = 1'b1;
                            end else begin
                                err = 1'b1;
                            end
                        end
                        MODE_FASTA: begin
                            if (b == CHAR_FASTA) hdr = 1'b1;
                            else role_eff = ROLE_DNA;
                        end
                        MODE_FQSEQ: begin
                            if (b == CHAR_PLUS) begin
                                n_mode   = MODE_FQQUAL;
                                role_eff = ROLE_SKIP;
                            end else begin
                                role_eff = ROLE_DNA;
                            end
                        end
                        default: begin
                            if (b == CHAR_FASTQ && r_bal == '0) begin
                                n_mode = MODE_FQSEQ;
                                hdr    = 1'b1;
                            end else begin
                                role_eff = ROLE_QUAL;
                            end
                        end
                    endcase
                    if (hdr) begin
                        role_eff  = ROLE_HEADER;
                        n_id_open = 1'b1;
                    end
                    n_role = role_eff;
                end else if (r_role == ROLE_HEADER && r_id_open) begin
                    if (b == CHAR_SPACE) begin
                        n_id_open = 1'b0;
                    end else begin
                        o_event.valid      = 1'b1;
                        o_event.event_kind = KIND_ID;
                        o_event.id_byte    = b;
                    end
                end
                if (!err) begin
                    if (role_eff == ROLE_DNA && !is_dna(b)) begin
                        err      = 1'b1;
                        err_code = ERR_SEQ;
                        err_col  = 16'(col_inc);
                    end else if (role_eff == ROLE_QUAL &&
                                 (b < i_qual_min || b > i_qual_max)) begin
                        err      = 1'b1;
                        err_code = ERR_QUAL;
                        err_col  = 16'(col_inc);
                    end
                end
            end else begin
                case (r_role)
                    ROLE_LSTART: begin
                        if (r_mode == MODE_START) err = 1'b1;
                        else if (r_mode == MODE_FQSEQ) bal_up = 1'b1;
                        else if (r_mode == MODE_FQQUAL) bal_dn = 1'b1;
                    end
                    ROLE_HEADER: begin
                        o_event.valid           = 1'b1;
                        o_event.event_kind      = KIND_RECORD;
                        o_event.record_offset   = 32'(n_offset);
                        o_event.record_is_fastq = (r_mode == MODE_FQSEQ);
                    end
                    ROLE_DNA: begin
                        if (r_mode == MODE_FQSEQ) bal_up = 1'b1;
                    end
                    ROLE_QUAL: begin
                        bal_dn = 1'b1;
                    end
                    default: ;
                endcase
                if (bal_up && r_bal != BAL_MAX) n_bal = r_bal + BAL_BITS'(1);
                if (bal_dn && r_bal != BAL_MIN) n_bal = r_bal - BAL_BITS'(1);
                if (r_line != '1) n_line = r_line + 1'b1;
                n_col     = '0;
                n_role    = ROLE_LSTART;
                n_id_open = 1'b0;
            end

            if (err) begin
                o_event              = '0;
                o_event.valid        = 1'b1;
                o_event.event_kind   = KIND_ERROR;
                o_event.error_code   = err_code;
                o_event.error_line   = 32'(r_line);
                o_event.error_column = err_col;
                n_halted             = 1'b1;
            end else if (i_item.end_of_input) begin
                n_mode    = MODE_START;
                n_role    = ROLE_LSTART;
                n_id_open = 1'b0;
                n_offset  = '0;
                n_line    = LINE_BITS'(1);
                n_col     = '0;
                n_bal     = '0;
                n_halted  = 1'b0;
            end
        end
    end

    `ASSERT_NEXT(a_error_halts, i_clk, i_rst_n,
        o_event.valid && o_event.event_kind == KIND_ERROR, r_halted)
    `ASSERT_IMPLIES(a_halted_silent, i_clk, i_rst_n, r_halted, !o_event.valid)
    `ASSERT_NEXT(a_line_advance, i_clk, i_rst_n,
        i_step && !r_halted && b == CHAR_NEWLINE && !i_item.end_of_input &&
        !o_event.valid && r_line != '1 && r_role != ROLE_LSTART,
        r_line == $past(r_line) + 1'b1)

endmodule

// ----- rtl/fasta_fastq_stream_indexer.sv -----
// top level of the sequence file indexer: config registers, stages and result register
//
// Usage: file bytes enter on the s_axis channel, one byte per transfer, with
// s_axis_tlast marking the final byte of a file. Results leave on m_axis: the
// event kind travels in m_axis_tuser, the remaining fields in m_axis_tdata.
// A byte produces at most one result: an identifier byte, a record start with
// the offset just after the header newline, or an error, after which the block
// swallows bytes silently until reset. The quality range is set through the
// cfg write channel (index 0 lowest, index 1 highest quality byte); the user
// must write it only while no byte is in flight, which the block does not
// enforce. o_cfg_ready is always high. Throughput is one byte per cycle while
// m_axis_tready is high. A byte accepted into the input register is parsed
// from there; its result enters the output register when the parser takes it.
// Reset (synchronous, active low) clears the parser to the start of a file and
// loads the default quality range 33 to 74. When m_axis_tready is low and the
// output register holds a result, an empty input register still takes one
// byte, then s_axis_tready stays low until the result transfer completes.
module fasta_fastq_stream_indexer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // data_byte
    input  logic                                 s_axis_tlast,  // end_of_input
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // id_byte, record_offset, record_is_fastq, error_code, error_line, error_column, pad
    output logic [ffsi_pkg::TDATA_BITS-1:0]      m_axis_tdata,
    output logic [ffsi_pkg::TUSER_BITS-1:0]      m_axis_tuser,  // event_kind
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ffsi_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [7:0]                           i_cfg_data
);
    import ffsi_pkg::*;

    logic [7:0] r_qual_min;
    logic [7:0] r_qual_max;
    logic       r_out_valid;
    t_event     r_out;

    t_item  in_item;
    t_item  stage_item;
    logic   stage_valid;
    logic   take;
    t_event ev;

    assign in_item.data_byte    = s_axis_tdata;
    assign in_item.end_of_input = s_axis_tlast;
    assign take                 = stage_valid && (!r_out_valid || m_axis_tready);
    assign o_cfg_ready          = 1'b1;

    ffsi_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    ffsi_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (take),
        .i_item     (stage_item),
        .i_qual_min (r_qual_min),
        .i_qual_max (r_qual_max),
        .o_event    (ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qual_min <= QUAL_MIN_RESET;
            r_qual_max <= QUAL_MAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_QUAL_MIN: r_qual_min <= i_cfg_data;
                CFG_QUAL_MAX: r_qual_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= ev.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && ev.valid) begin
            r_out <= ev;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.event_kind;
    assign m_axis_tdata  = {5'd0, r_out.error_column, r_out.error_line, r_out.error_code,
                            r_out.record_is_fastq, r_out.record_offset, r_out.id_byte};

endmodule

// ----- tb/tb_fasta_fastq_stream_indexer.sv -----
`timescale 1ns / 1ps
// testbench of the sequence file indexer: byte streams checked against a behavioral parser
module tb_fasta_fastq_stream_indexer;
    import ffsi_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int LATENCY         = 4;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 84;
    localparam int NUM_ROWS        = 26;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  id;
        logic [31:0] offset;
        logic        fastq;
        t_err        code;
        logic [31:0] line;
        logic [15:0] column;
    } t_exp;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic        typed;
        t_kind       kind;
        logic [7:0]  id;
        logic [31:0] offset;
        logic        fastq;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata = 8'h00;
    logic                      s_axis_tlast = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [TDATA_BITS-1:0]     m_axis_tdata;
    logic [TUSER_BITS-1:0]     m_axis_tuser;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = CFG_QUAL_MIN;
    logic [7:0]                i_cfg_data = 8'h00;

    int src_idle_pct = 22;
    int snk_idle_pct = 81;
    int fails = 0;
    int cycle_count = 0;

    t_exp pending_events[$];

    // parser state mirrored from the block
    t_mode              mode;
    t_role              role;
    logic               id_open;
    logic [31:0]        byte_pos;
    logic [31:0]        line_no;
    logic [15:0]        col_no;
    logic signed [15:0] balance;
    logic               halted;
    logic [7:0]         qual_lo;
    logic [7:0]         qual_hi;

    t_row directed_rows [NUM_ROWS] = '{
        '{CHAR_FASTA,   1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{"a",          1'b0, 1'b1, KIND_ID,     "a",   32'd0,  1'b0},
        '{8'hFF,        1'b0, 1'b1, KIND_ID,     8'hFF, 32'd0,  1'b0},
        '{8'h00,        1'b0, 1'b1, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{CHAR_SPACE,   1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{"x",          1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{CHAR_NEWLINE, 1'b0, 1'b1, KIND_RECORD, 8'h00, 32'd7,  1'b0},
        '{"N",          1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{"a",          1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{CHAR_NEWLINE, 1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{CHAR_NEWLINE, 1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{CHAR_FASTA,   1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{CHAR_NEWLINE, 1'b0, 1'b1, KIND_RECORD, 8'h00, 32'd13, 1'b0},
        '{"g",          1'b1, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{CHAR_FASTQ,   1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{"r",          1'b0, 1'b1, KIND_ID,     "r",   32'd0,  1'b0},
        '{CHAR_NEWLINE, 1'b0, 1'b1, KIND_RECORD, 8'h00, 32'd3,  1'b1},
        '{"T",          1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{CHAR_NEWLINE, 1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{CHAR_PLUS,    1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{8'h00,        1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{CHAR_NEWLINE, 1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{"J",          1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{"!",          1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{CHAR_NEWLINE, 1'b0, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0},
        '{CHAR_FASTQ,   1'b1, 1'b0, KIND_ID,     8'h00, 32'd0,  1'b0}
    };

    fasta_fastq_stream_indexer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial forever #5 i_clk = ~i_clk;

    function automatic void restart_file();
        mode = MODE_START;
        role = ROLE_LSTART;
        id_open = 1'b0;
        byte_pos = '0;
        line_no = 32'd1;
        col_no = '0;
        balance = '0;
        halted = 1'b0;
    endfunction

    function automatic void queue_event(t_exp e);
        pending_events = {pending_events, e};
    endfunction

    function automatic logic dna_symbol(logic [7:0] b);
        case (b)
            "a", "c", "g", "t", "n", "A", "C", "G", "T", "N": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_exp halt_on(t_err code, logic [15:0] column);
        t_exp e = '0;
        e.kind = KIND_ERROR;
        e.code = code;
        e.line = line_no;
        e.column = column;
        halted = 1'b1;
        return e;
    endfunction

    function automatic void shift_balance(logic up);
        if (up && balance != BAL_MAX) begin
            balance = balance + 16'sd1;
        end else if (!up && balance != BAL_MIN) begin
            balance = balance - 16'sd1;
        end
    endfunction

    // one file byte through the parser, returns the event it causes if any
    task automatic index_byte(input logic [7:0] b, input logic last,
                              output logic hit, output t_exp ev);
        logic hdr;
        hit = 1'b0;
        ev = '0;
        hdr = 1'b0;
        if (halted) return;
        byte_pos = byte_pos + 32'd1;
        if (b != CHAR_NEWLINE) begin
            if (col_no != '1) col_no = col_no + 16'd1;
            if (role == ROLE_LSTART) begin
                case (mode)
                    MODE_START: begin
                        if (b == CHAR_FASTA) begin
                            mode = MODE_FASTA;
                            hdr = 1'b1;
                        end else if (b == CHAR_FASTQ) begin
                            mode = MODE_FQSEQ;
                            hdr = 1'b1;
                        end else begin
                            ev = halt_on(ERR_MALFORMED, 16'd1);
                            hit = 1'b1;
                            return;
                        end
                    end
                    MODE_FASTA: begin
                        if (b == CHAR_FASTA) hdr = 1'b1;
                        else role = ROLE_DNA;
                    end
                    MODE_FQSEQ: begin
                        if (b == CHAR_PLUS) begin
                            mode = MODE_FQQUAL;
                            role = ROLE_SKIP;
                        end else begin
                            role = ROLE_DNA;
                        end
                    end
                    default: begin
                        if (b == CHAR_FASTQ && balance == 0) begin
                            mode = MODE_FQSEQ;
                            hdr = 1'b1;
                        end else begin
                            role = ROLE_QUAL;
                        end
                    end
                endcase
                if (hdr) begin
                    role = ROLE_HEADER;
                    id_open = 1'b1;
                end
            end else if (role == ROLE_HEADER && id_open) begin
                if (b == CHAR_SPACE) begin
                    id_open = 1'b0;
                end else begin
                    ev.kind = KIND_ID;
                    ev.id = b;
                    hit = 1'b1;
                end
            end
            if (role == ROLE_DNA && !dna_symbol(b)) begin
                ev = halt_on(ERR_SEQ, col_no);
                hit = 1'b1;
                return;
            end
            if (role == ROLE_QUAL && (b < qual_lo || b > qual_hi)) begin
                ev = halt_on(ERR_QUAL, col_no);
                hit = 1'b1;
                return;
            end
        end else begin
            case (role)
                ROLE_LSTART: begin
                    if (mode == MODE_START) begin
                        ev = halt_on(ERR_MALFORMED, 16'd1);
                        hit = 1'b1;
                        return;
                    end
                    if (mode == MODE_FQSEQ) shift_balance(1'b1);
                    else if (mode == MODE_FQQUAL) shift_balance(1'b0);
                end
                ROLE_HEADER: begin
                    ev.kind = KIND_RECORD;
                    ev.offset = byte_pos;
                    ev.fastq = (mode == MODE_FQSEQ);
                    hit = 1'b1;
                end
                ROLE_DNA: begin
                    if (mode == MODE_FQSEQ) shift_balance(1'b1);
                end
                ROLE_QUAL: shift_balance(1'b0);
                default: ;
            endcase
            if (line_no != '1) line_no = line_no + 32'd1;
            col_no = '0;
            role = ROLE_LSTART;
            id_open = 1'b0;
        end
        if (last) restart_file();
    endtask

    function automatic logic [7:0] any_byte_but_newline();
        logic [7:0] v;
        v = 8'($urandom_range(255));
        if (v == CHAR_NEWLINE) v = ~v;
        return v;
    endfunction

    function automatic logic [7:0] dna_byte();
        string bases;
        bases = "acgtnACGTN";
        return bases[$urandom_range(9)];
    endfunction

    function automatic logic quality_possible();
        return qual_lo <= qual_hi && !(qual_lo == CHAR_NEWLINE && qual_hi == CHAR_NEWLINE);
    endfunction

    function automatic logic [7:0] quality_byte();
        logic [7:0] v;
        v = 8'($urandom_range(qual_hi, qual_lo));
        if (v == CHAR_NEWLINE) v = (qual_hi > CHAR_NEWLINE) ? 8'd11 : 8'd9;
        return v;
    endfunction

    // legal next byte of a file, given where the parser stands
    function automatic logic [7:0] next_file_byte();
        int r;
        r = $urandom_range(99);
        case (role)
            ROLE_LSTART: begin
                case (mode)
                    MODE_START: return (r < 50) ? CHAR_FASTA : CHAR_FASTQ;
                    MODE_FASTA: return (r < 15) ? CHAR_FASTA :
                                       (r < 20) ? CHAR_NEWLINE : dna_byte();
                    MODE_FQSEQ: return (r < 35) ? CHAR_PLUS :
                                       (r < 40) ? CHAR_NEWLINE : dna_byte();
                    default: begin
                        if (balance == 0 && r < 85) return CHAR_FASTQ;
                        return (quality_possible() && r % 10 != 0) ? quality_byte()
                                                                   : CHAR_NEWLINE;
                    end
                endcase
            end
            ROLE_HEADER: return (r < 12) ? CHAR_NEWLINE :
                                (r < 22) ? CHAR_SPACE : any_byte_but_newline();
            ROLE_DNA:    return (r < 10) ? CHAR_NEWLINE : dna_byte();
            ROLE_QUAL:   return (r < 10 || !quality_possible()) ? CHAR_NEWLINE
                                                                : quality_byte();
            default:     return (r < 25) ? CHAR_NEWLINE : any_byte_but_newline();
        endcase
    endfunction

    // ends files often once the line balance has gone negative
    function automatic logic end_here();
        if (balance < 0) return $urandom_range(4) == 0;
        return $urandom_range(99) == 0;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last,
                             output logic hit, output t_exp ev);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        index_byte(b, last, hit, ev);
    endtask

    task automatic stream_byte(input logic [7:0] b, input logic last);
        logic hit;
        t_exp ev;
        send_byte(b, last, hit, ev);
        if (hit) queue_event(ev);
    endtask

    task automatic set_quality_range(input logic [7:0] lo, input logic [7:0] hi);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_QUAL_MIN;
        i_cfg_data <= lo;
        do @(posedge i_clk); while (!o_cfg_ready);
        qual_lo = lo;
        i_cfg_index <= CFG_QUAL_MAX;
        i_cfg_data <= hi;
        do @(posedge i_clk); while (!o_cfg_ready);
        qual_hi = hi;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending_events.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_events.size() != 0) begin
            $error("%0d expected events never arrived", pending_events.size());
            fails++;
            pending_events.delete();
        end
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_exp want;
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_events.size() == 0) begin
                $error("event of kind %0d with none expected", m_axis_tuser);
                fails++;
            end else begin
                want = pending_events.pop_front();
                compare_field("event_kind", 32'(want.kind), 32'(m_axis_tuser));
                compare_field("id_byte", 32'(want.id), 32'(m_axis_tdata[7:0]));
                compare_field("record_offset", want.offset, m_axis_tdata[39:8]);
                compare_field("record_is_fastq", 32'(want.fastq), 32'(m_axis_tdata[40]));
                compare_field("error_code", 32'(want.code), 32'(m_axis_tdata[42:41]));
                compare_field("error_line", want.line, m_axis_tdata[74:43]);
                compare_field("error_column", 32'(want.column), 32'(m_axis_tdata[90:75]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic       hit;
        t_exp       ev;
        logic [7:0] b;
        int         n;
        t_err       finale;
        restart_file();
        qual_lo = QUAL_MIN_RESET;
        qual_hi = QUAL_MAX_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_ROWS; k++) begin
            send_byte(directed_rows[k].data, directed_rows[k].last, hit, ev);
            if (directed_rows[k].typed) begin
                ev = '0;
                ev.kind = directed_rows[k].kind;
                ev.id = directed_rows[k].id;
                ev.offset = directed_rows[k].offset;
                ev.fastq = directed_rows[k].fastq;
                queue_event(ev);
            end else if (hit) begin
                queue_event(ev);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 2) begin
                src_idle_pct = 81;
                snk_idle_pct = 22;
            end else if (phase == 4) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if (phase > 0) begin
                s_axis_tvalid <= 1'b0;
                drain();
                case (phase)
                    1: set_quality_range(8'h00, 8'hFF);
                    2: set_quality_range(8'hFF, 8'h00);
                    3: set_quality_range(CHAR_FASTQ, CHAR_FASTQ);
                    4: set_quality_range(CHAR_NEWLINE, CHAR_NEWLINE);
                    default: set_quality_range(8'($urandom_range(255)),
                                               8'($urandom_range(255)));
                endcase
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                b = next_file_byte();
                stream_byte(b, end_here());
            end
        end

        // close the open file, then end the run on one error of a random kind
        b = next_file_byte();
        stream_byte(b, 1'b1);
        s_axis_tvalid <= 1'b0;
        drain();
        set_quality_range(QUAL_MIN_RESET, QUAL_MAX_RESET);
        finale = t_err'($urandom_range(2));
        case (finale)
            ERR_MALFORMED: begin
                b = any_byte_but_newline();
                if (b == CHAR_FASTA || b == CHAR_FASTQ) b = CHAR_NEWLINE;
                stream_byte(b, 1'b0);
            end
            ERR_SEQ: begin
                stream_byte(CHAR_FASTA, 1'b0);
                stream_byte(any_byte_but_newline(), 1'b0);
                stream_byte(CHAR_NEWLINE, 1'b0);
                n = $urandom_range(20);
                repeat (n) stream_byte(dna_byte(), 1'b0);
                b = any_byte_but_newline();
                if (dna_symbol(b) || b == CHAR_FASTA) b = "!";
                stream_byte(b, 1'b0);
            end
            default: begin
                stream_byte(CHAR_FASTQ, 1'b0);
                stream_byte("r", 1'b0);
                stream_byte(CHAR_NEWLINE, 1'b0);
                stream_byte("A", 1'b0);
                stream_byte(CHAR_NEWLINE, 1'b0);
                stream_byte(CHAR_PLUS, 1'b0);
                stream_byte(CHAR_NEWLINE, 1'b0);
                repeat ($urandom_range(5)) stream_byte(quality_byte(), 1'b0);
                b = $urandom_range(1) ? 8'($urandom_range(255, 75))
                                      : 8'($urandom_range(32, 0));
                if (b == CHAR_NEWLINE) b = 8'h00;
                stream_byte(b, 1'b0);
            end
        endcase
        // halted: these bytes must vanish
        repeat (12) stream_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        s_axis_tvalid <= 1'b0;
        drain();

        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
